// ===== hdl/imu_tcf_pkg.sv =====
// Shared types, constants and fixed-point helpers of the IMU tilt filter.
package imu_tcf_pkg;

  localparam int RAW_W  = 16;
  localparam int NCH    = 5;
  localparam int SUM_W  = 33;
  localparam int OFF_W  = 24;
  localparam int MEAS_W = 27;
  localparam int MUL_W  = 54;
  localparam int DEN_W  = 27;
  localparam int SQ_W   = 52;
  localparam int ANG_W  = 27;
  localparam int STATE_W = 24;
  localparam int DELTA_W = 26;

  localparam int CH_AX = 0;
  localparam int CH_AY = 1;
  localparam int CH_AZ = 2;
  localparam int CH_GX = 3;
  localparam int CH_GY = 4;

  localparam logic signed [MEAS_W-1:0] GRAVITY_Q8 = 27'sd4194304;
  localparam logic [DEN_W-1:0]         GYRO_DIV   = 27'd131070000;
  localparam logic signed [ANG_W-1:0]  HALF_TURN  = 27'sd11796480;

  localparam logic [15:0] WEIGHT_RST  = 16'd64225;
  localparam logic [19:0] STEP_RST    = 20'd10000;
  localparam logic [15:0] CALCNT_RST  = 16'd1000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_CAL   = 2'd1,
    OP_MEAS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_GYRO_WEIGHT = 2'd0,
    CFG_STEP_TIME   = 2'd1,
    CFG_CAL_COUNT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] a;
    case (idx)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  // round to nearest, ties away from zero, divide by 2**k
  function automatic logic signed [55:0] rnd_shr(input logic signed [55:0] v,
                                                 input int unsigned k);
    logic [55:0] mag;
    mag = v[55] ? 56'(-v) : 56'(v);
    mag = (mag + (56'd1 << (k - 1))) >> k;
    return v[55] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [55:0] sat56(input logic signed [55:0] v,
                                               input logic signed [55:0] lo,
                                               input logic signed [55:0] hi);
    logic signed [55:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

endpackage

// ===== hdl/imu_tilt_complementary_filter.sv =====
// Top level of the IMU tilt complementary filter: sequencer, multiplier and state.
//
// Input channel in_*: one word per sample. in_tuser holds the operation (clear
// calibration, calibration sample, measure sample); in_tdata holds the five raw
// sensor values. Every accepted word yields exactly one result word on out_*,
// carrying blended roll and pitch, accelerometer-only roll and pitch, the
// calibrated flag and the calibration sample count.
// Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_index (0 gyro
// weight, 1 step time in us, 2 calibration count); the user is to write only while
// the block is idle, which the block itself does not enforce. A clear or ignored word
// and a calibration sample need no arithmetic unit; the closing calibration sample
// runs five divisions, and a measure sample 26 square-root steps, two CORDIC runs of
// up to CORDIC_STEPS micro-rotations and two divisions for the gyro increments,
// with one 27x27 multiplier shared over the squares, rate scaling and blends.
// One word is in work at a time; in_tready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and the
// block accepts the next word, finishing it once the register is free.
// Reset (synchronous, rst_n low) clears calibration, angles and configuration
// to their defaults and drops out_tvalid.
module imu_tilt_complementary_filter import imu_tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // roll_angle, pitch_angle, accel_roll, accel_pitch,
                                  // calibrated, samples_collected
);

  typedef enum logic [4:0] {
    S_IDLE, S_CAL_GO, S_CAL_WT, S_SQ0, S_SQ1, S_SQ2, S_SQ_WT,
    S_RCD_GO, S_RCD_WT, S_PCD_GO, S_PCD_WT, S_GX, S_DX_GO, S_DX_WT,
    S_GY, S_DY_GO, S_DY_WT, S_BL0, S_BL1, S_BL2, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] w_r;
  logic [19:0] dt_r;
  logic [15:0] calcnt_r;

  logic signed [SUM_W-1:0]   sums_r [NCH];
  logic signed [OFF_W-1:0]   offs_r [NCH];
  logic signed [MEAS_W-1:0]  meas_r [NCH];
  logic [15:0]               cnt_r;
  logic                      valid_r;
  logic [2:0]                ch_r;
  logic                      sel_r;
  logic signed [STATE_W-1:0] roll_r;
  logic signed [STATE_W-1:0] pitch_r;
  logic signed [15:0]        la_roll_r;
  logic signed [14:0]        la_pitch_r;
  logic signed [MUL_W-1:0]   prod_r;
  logic signed [MUL_W-1:0]   acc_r;
  logic [SQ_W/2-1:0]         r_r;
  logic signed [ANG_W-1:0]   rz_r;
  logic signed [ANG_W-1:0]   pz_r;
  logic signed [DELTA_W-1:0] dr_r;
  logic signed [DELTA_W-1:0] dp_r;
  logic                      out_valid_r;
  logic [79:0]               out_data_r;

  logic signed [RAW_W-1:0]   raw [NCH];
  logic [15:0]               cnt_inc;
  logic [15:0]               need;
  logic                      accept;
  logic signed [MEAS_W-1:0]  mul_a;
  logic signed [MEAS_W-1:0]  mul_b;
  logic signed [STATE_W-1:0] prev;
  logic signed [DELTA_W-1:0] delta;
  logic signed [ANG_W-1:0]   acc_fine;
  logic signed [55:0]        blend;
  logic signed [15:0]        roll_out;
  logic signed [15:0]        pitch_out;

  logic                      div_start;
  logic signed [MUL_W-1:0]   div_num;
  logic [DEN_W-1:0]          div_den;
  logic signed [MUL_W-1:0]   div_quo;
  unit_sts_t                 div_sts;
  logic                      sq_start;
  logic [SQ_W-1:0]           sq_val;
  logic [SQ_W/2-1:0]         sq_root;
  unit_sts_t                 sq_sts;
  logic                      cor_start;
  logic signed [ANG_W-1:0]   cor_x;
  logic signed [ANG_W-1:0]   cor_y;
  logic signed [ANG_W-1:0]   cor_z;
  unit_sts_t                 cor_sts;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      raw[i] = in_tdata[RAW_W*i +: RAW_W];
    end
    accept  = in_tvalid && in_tready;
    cnt_inc = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
    need    = (calcnt_r == 16'd0) ? 16'd1 : calcnt_r;

    prev     = sel_r ? pitch_r : roll_r;
    delta    = sel_r ? dp_r : dr_r;
    acc_fine = ANG_W'(rnd_shr(56'(sel_r ? pz_r : rz_r), 1));
    case (state_r)
      S_SQ0: begin
        mul_a = meas_r[CH_AY];
        mul_b = meas_r[CH_AY];
      end
      S_SQ1: begin
        mul_a = meas_r[CH_AZ];
        mul_b = meas_r[CH_AZ];
      end
      S_GX: begin
        mul_a = meas_r[CH_GX];
        mul_b = $signed({7'd0, dt_r});
      end
      S_GY: begin
        mul_a = meas_r[CH_GY];
        mul_b = $signed({7'd0, dt_r});
      end
      S_BL0: begin
        mul_a = $signed({11'd0, w_r});
        mul_b = MEAS_W'(prev) + MEAS_W'(delta);
      end
      S_BL1: begin
        mul_a = $signed({10'd0, 17'h10000 - {1'b0, w_r}});
        mul_b = acc_fine;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    blend = sat56(rnd_shr(56'(acc_r) + 56'(prod_r), 16), -56'sd8388608, 56'sd8388607);

    div_start = (state_r == S_CAL_GO) || (state_r == S_DX_GO) || (state_r == S_DY_GO);
    div_num   = (state_r == S_CAL_GO) ? (MUL_W'(sums_r[ch_r]) <<< 8) : (prod_r <<< 7);
    div_den   = (state_r == S_CAL_GO) ? DEN_W'(cnt_r) : GYRO_DIV;

    sq_start  = (state_r == S_SQ2);
    sq_val    = SQ_W'($unsigned(acc_r + prod_r));

    cor_start = (state_r == S_RCD_GO) || (state_r == S_PCD_GO);
    cor_x     = (state_r == S_RCD_GO) ? meas_r[CH_AZ] : $signed({1'b0, r_r});
    cor_y     = (state_r == S_RCD_GO) ? meas_r[CH_AY] : -meas_r[CH_AX];

    roll_out  = 16'(sat56(rnd_shr(56'(roll_r), 8), -56'sd32768, 56'sd32767));
    pitch_out = 16'(sat56(rnd_shr(56'(pitch_r), 8), -56'sd32768, 56'sd32767));
  end

  imu_tcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  imu_tcf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .root  (sq_root),
    .sts   (sq_sts)
  );

  imu_tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .z     (cor_z),
    .sts   (cor_sts)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= WEIGHT_RST;
      dt_r        <= STEP_RST;
      calcnt_r    <= CALCNT_RST;
      for (int i = 0; i < NCH; i++) begin
        sums_r[i] <= '0;
        offs_r[i] <= '0;
      end
      cnt_r       <= '0;
      valid_r     <= 1'b0;
      roll_r      <= '0;
      pitch_r     <= '0;
      la_roll_r   <= '0;
      la_pitch_r  <= '0;
      sel_r       <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GYRO_WEIGHT: w_r      <= cfg_wdata[15:0];
          CFG_STEP_TIME:   dt_r     <= cfg_wdata;
          CFG_CAL_COUNT:   calcnt_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_tuser)
              OP_CLEAR: begin
                for (int i = 0; i < NCH; i++) begin
                  sums_r[i] <= '0;
                  offs_r[i] <= '0;
                end
                cnt_r   <= '0;
                valid_r <= 1'b0;
                state_r <= S_OUT;
              end
              OP_CAL: begin
                state_r <= S_OUT;
                if (!valid_r) begin
                  for (int i = 0; i < NCH; i++) begin
                    sums_r[i] <= sums_r[i] + SUM_W'(raw[i]);
                  end
                  cnt_r <= cnt_inc;
                  if (cnt_inc >= need) begin
                    ch_r    <= '0;
                    state_r <= S_CAL_GO;
                  end
                end
              end
              OP_MEAS: begin
                for (int i = 0; i < NCH; i++) begin
                  meas_r[i] <= (MEAS_W'(raw[i]) <<< 8) - MEAS_W'(offs_r[i]);
                end
                meas_r[CH_AZ] <= (MEAS_W'(raw[CH_AZ]) <<< 8) - MEAS_W'(offs_r[CH_AZ])
                                 + GRAVITY_Q8;
                sel_r   <= 1'b0;
                state_r <= S_SQ0;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_CAL_GO: state_r <= S_CAL_WT;
        S_CAL_WT: begin
          if (div_sts.done) begin
            offs_r[ch_r] <= OFF_W'(sat56(56'(div_quo), -56'sd8388608, 56'sd8388607));
            if (ch_r == 3'(NCH - 1)) begin
              valid_r <= 1'b1;
              state_r <= S_OUT;
            end else begin
              ch_r    <= ch_r + 3'd1;
              state_r <= S_CAL_GO;
            end
          end
        end
        S_SQ0: state_r <= S_SQ1;
        S_SQ1: begin
          acc_r   <= prod_r;
          state_r <= S_SQ2;
        end
        S_SQ2: state_r <= S_SQ_WT;
        S_SQ_WT: begin
          if (sq_sts.done) begin
            r_r     <= sq_root;
            state_r <= S_RCD_GO;
          end
        end
        S_RCD_GO: state_r <= S_RCD_WT;
        S_RCD_WT: begin
          if (cor_sts.done) begin
            rz_r    <= cor_z;
            state_r <= S_PCD_GO;
          end
        end
        S_PCD_GO: state_r <= S_PCD_WT;
        S_PCD_WT: begin
          if (cor_sts.done) begin
            pz_r       <= cor_z;
            la_roll_r  <= 16'(sat56(rnd_shr(56'(rz_r), 9), -56'sd23040, 56'sd23040));
            la_pitch_r <= 15'(sat56(rnd_shr(56'(cor_z), 9), -56'sd11520, 56'sd11520));
            state_r    <= S_GX;
          end
        end
        S_GX:    state_r <= S_DX_GO;
        S_DX_GO: state_r <= S_DX_WT;
        S_DX_WT: begin
          if (div_sts.done) begin
            dr_r    <= DELTA_W'(div_quo);
            state_r <= S_GY;
          end
        end
        S_GY:    state_r <= S_DY_GO;
        S_DY_GO: state_r <= S_DY_WT;
        S_DY_WT: begin
          if (div_sts.done) begin
            dp_r    <= DELTA_W'(div_quo);
            state_r <= S_BL0;
          end
        end
        S_BL0: state_r <= S_BL1;
        S_BL1: begin
          acc_r   <= prod_r;
          state_r <= S_BL2;
        end
        S_BL2: begin
          if (!sel_r) begin
            roll_r  <= STATE_W'(blend);
            sel_r   <= 1'b1;
            state_r <= S_BL0;
          end else begin
            pitch_r <= STATE_W'(blend);
            sel_r   <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {cnt_r, valid_r, la_pitch_r, la_roll_r, pitch_out, roll_out};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(div_sts.busy || sq_sts.busy || cor_sts.busy))
    else $error("word accepted while an arithmetic unit is busy");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> (cnt_r == 16'd0) || (cnt_r == $past(cnt_r) + 16'd1))
    else $error("sample count moved by other than one or clear");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(state_r == S_CAL_WT))
    else $error("calibrated flag set outside offset division");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_tready)) |=> out_tvalid && in_tready)
    else $error("result not presented after completion");

endmodule

// ===== hdl/imu_tcf_div.sv =====
// Radix-2 restoring divider, signed numerator, rounded to nearest.
module imu_tcf_div import imu_tcf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [MUL_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [MUL_W-1:0] quo,
  output unit_sts_t               sts
);

  localparam int MAG_W = MUL_W + 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;

  logic [MAG_W-1:0] mag;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    mag   = (num < 0) ? MAG_W'(-num) : MAG_W'(num);
    mag   = mag + MAG_W'(den >> 1);
    trial = {rem_r, q_r[MAG_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= (num < 0);
        cnt_r  <= CNT_W'(MAG_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[MAG_W-2:0], ge};
        rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo      = neg_r ? -$signed(q_r[MUL_W-1:0]) : $signed(q_r[MUL_W-1:0]);
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== hdl/imu_tcf_sqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
module imu_tcf_sqrt import imu_tcf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SQ_W-1:0]       val,
  output logic [SQ_W/2-1:0]     root,
  output unit_sts_t             sts
);

  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= val;
        r_r    <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root     = r_r[SQ_W/2-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== hdl/imu_tcf_cordic.sv =====
// Vectoring CORDIC for atan2, one micro-rotation per cycle, angle in 2^-16 degree.
module imu_tcf_cordic import imu_tcf_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] x_in,
  input  logic signed [ANG_W-1:0] y_in,
  output logic signed [ANG_W-1:0] z,
  output unit_sts_t               sts
);

  localparam int CW    = 40;
  localparam int CNT_W = $clog2(STEPS);

  logic signed [CW-1:0]    x_r;
  logic signed [CW-1:0]    y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic                    xneg;
  logic signed [ANG_W-1:0] xa;
  logic signed [ANG_W-1:0] ya;
  logic signed [ANG_W-1:0] z0;
  logic signed [CW-1:0]    sx;
  logic signed [CW-1:0]    sy;
  logic signed [ANG_W-1:0] ang;

  always_comb begin
    xneg = (x_in < 0);
    xa   = xneg ? -x_in : x_in;
    ya   = xneg ? -y_in : y_in;
    z0   = xneg ? ((y_in >= 0) ? HALF_TURN : -HALF_TURN) : '0;
    sx   = x_r >>> cnt_r;
    sy   = y_r >>> cnt_r;
    ang  = $signed(ANG_W'(atan_lut(5'(cnt_r))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= CW'(xa) <<< 8;
        y_r   <= CW'(ya) <<< 8;
        z_r   <= z0;
        cnt_r <= '0;
        if (ya == 0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (!y_r[CW-1]) begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - ang;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign z        = z_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== tb/imu_tilt_complementary_filter_tb.sv =====
// Self-checking testbench of the IMU tilt complementary filter: directed and random words.
`timescale 1ns / 100ps
module imu_tilt_complementary_filter_tb;
  import imu_tcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] acc_roll;
    logic [14:0] acc_pitch;
    logic        cal_done;
    logic [15:0] n_cal;
  } tilt_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_GYRO_WEIGHT;
  logic [19:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // accel_x, accel_y, accel_z, gyro_x, gyro_y
  op_t         in_tuser = OP_NONE;  // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // roll_angle, pitch_angle, accel_roll, accel_pitch,
                                // calibrated, samples_collected

  tilt_word_t tilt_q[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int mismatches = 0;
  int words_checked = 0;
  int words_sent = 0;
  int idle_cycles = 0;

  // filter mirror
  longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};
  longint gain_w, step_us, cal_target;
  longint cal_sum[5], ofs[5];
  longint n_samples;
  bit     ofs_ok;
  longint roll_q, pitch_q, acc_roll_q, acc_pitch_q;

  imu_tilt_complementary_filter DUT (.*);

  always #6 clk = ~clk;

  function automatic longint rdiv(longint n, longint d);
    if (n < 0) return -((-n + d / 2) / d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan2_fine(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    if (y == 0) return z;
    x *= 256;
    y *= 256;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_deg[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_deg[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint mix_angle(longint prev, longint delta, longint acc);
    return clip(rdiv(gain_w * (prev + delta) + (65536 - gain_w) * acc, 65536),
                -8388608, 8388607);
  endfunction

  function automatic void reset_mirror();
    gain_w = 64225;
    step_us = 10000;
    cal_target = 1000;
    foreach (cal_sum[i]) begin
      cal_sum[i] = 0;
      ofs[i] = 0;
    end
    n_samples = 0;
    ofs_ok = 0;
    roll_q = 0;
    pitch_q = 0;
    acc_roll_q = 0;
    acc_pitch_q = 0;
  endfunction

  function automatic tilt_word_t predict_tilt(op_t op, logic [79:0] raw_bits);
    longint raw[5];
    longint ax, ay, az, gx, gy, r, rz, pz, need;
    tilt_word_t t;
    for (int i = 0; i < 5; i++) raw[i] = longint'($signed(raw_bits[16*i +: 16]));
    case (op)
      OP_CLEAR: begin
        foreach (cal_sum[i]) begin
          cal_sum[i] = 0;
          ofs[i] = 0;
        end
        n_samples = 0;
        ofs_ok = 0;
      end
      OP_CAL: begin
        if (!ofs_ok) begin
          need = (cal_target == 0) ? 1 : cal_target;
          foreach (cal_sum[i]) cal_sum[i] += raw[i];
          if (n_samples < 65535) n_samples++;
          if (n_samples >= need) begin
            foreach (ofs[i]) ofs[i] = clip(rdiv(cal_sum[i] * 256, n_samples),
                                           -8388608, 8388607);
            ofs_ok = 1;
          end
        end
      end
      OP_MEAS: begin
        ax = raw[0] * 256 - ofs[0];
        ay = raw[1] * 256 - ofs[1];
        az = raw[2] * 256 - ofs[2] + 64'sd16384 * 256;
        gx = raw[3] * 256 - ofs[3];
        gy = raw[4] * 256 - ofs[4];
        r = int_sqrt(longint'(ay * ay) + longint'(az * az));
        rz = atan2_fine(az, ay);
        pz = atan2_fine(r, -ax);
        acc_roll_q = clip(rdiv(rz, 512), -23040, 23040);
        acc_pitch_q = clip(rdiv(pz, 512), -11520, 11520);
        roll_q = mix_angle(roll_q, rdiv(gx * step_us * 128, 131070000), rdiv(rz, 2));
        pitch_q = mix_angle(pitch_q, rdiv(gy * step_us * 128, 131070000), rdiv(pz, 2));
      end
      default: ;
    endcase
    t.roll = 16'(clip(rdiv(roll_q, 256), -32768, 32767));
    t.pitch = 16'(clip(rdiv(pitch_q, 256), -32768, 32767));
    t.acc_roll = 16'(acc_roll_q);
    t.acc_pitch = 15'(acc_pitch_q);
    t.cal_done = ofs_ok;
    t.n_cal = 16'(n_samples);
    return t;
  endfunction

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    tilt_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (tilt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        e = tilt_q.pop_front();
        if (out_tdata[15:0] !== e.roll || out_tdata[31:16] !== e.pitch ||
            out_tdata[47:32] !== e.acc_roll || out_tdata[62:48] !== e.acc_pitch ||
            out_tdata[63] !== e.cal_done || out_tdata[79:64] !== e.n_cal) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp roll %h pitch %h aroll %h apitch %h cal %b n %0d, got %h",
                     e.roll, e.pitch, e.acc_roll, e.acc_pitch, e.cal_done, e.n_cal,
                     out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(op_t op, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           logic [15:0] gx, logic [15:0] gy);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {gy, gx, az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tilt_q.push_back(predict_tilt(op, {gy, gx, az, ay, ax}));
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tilt_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [19:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_GYRO_WEIGHT: gain_w = val[15:0];
      CFG_STEP_TIME:   step_us = val;
      default:         cal_target = val[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_random(op_t op);
    logic [15:0] v[5];
    bit tame;
    tame = ($urandom_range(99) < 60);
    foreach (v[i]) v[i] = $urandom;
    if (tame) begin
      v[0] = 16'($signed($urandom_range(8000)) - 4000);
      v[1] = 16'($signed($urandom_range(8000)) - 4000);
      v[2] = 16'($signed($urandom_range(8000)) + 12000);
      v[3] = 16'($signed($urandom_range(2000)) - 1000);
      v[4] = 16'($signed($urandom_range(2000)) - 1000);
    end
    send_word(op, v[0], v[1], v[2], v[3], v[4]);
  endtask

  task automatic test_directed();
    send_word(OP_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_MEAS, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(OP_MEAS, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000);
    send_word(OP_MEAS, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(OP_MEAS, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
    drain();
    write_reg(CFG_CAL_COUNT, 20'd5);
    send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_CAL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(OP_CAL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(OP_CAL, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
    drain();
    write_reg(CFG_CAL_COUNT, 20'd2);
    send_word(OP_CAL, 16'h0003, 16'hFFFD, 16'h4000, 16'h0000, 16'h0002);
    send_word(OP_CAL, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
    send_word(OP_MEAS, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_word(OP_NONE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    drain();
    write_reg(CFG_CAL_COUNT, 20'd0);
    send_word(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_CAL, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF);
    send_word(OP_MEAS, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(CFG_CAL_COUNT, 20'd65535);
    send_word(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_CAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_CAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_MEAS, 16'h0100, 16'hFF00, 16'h4000, 16'h0080, 16'hFF80);
    drain();
  endtask

  task automatic run_session(int n_meas);
    send_random(OP_CLEAR);
    for (int i = 0; i < ((cal_target == 0) ? 1 : cal_target); i++) send_random(OP_CAL);
    for (int i = 0; i < n_meas; i++) begin
      case ($urandom_range(99)) inside
        [0:3]:   send_random(OP_NONE);
        [4:6]:   send_random(OP_CAL);
        [7:8]:   send_random(OP_CLEAR);
        default: send_random(OP_MEAS);
      endcase
    end
  endtask

  task automatic test_random_phase(int n_words, logic [15:0] w, logic [19:0] dt,
                                   logic [15:0] nc);
    int stop_at;
    drain();
    write_reg(CFG_GYRO_WEIGHT, w);
    write_reg(CFG_STEP_TIME, dt);
    write_reg(CFG_CAL_COUNT, nc);
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) run_session($urandom_range(10, 40));
  endtask

  task automatic test_backpressure();
    rx_hold_left = 1500;
    for (int i = 0; i < 12; i++) send_random(OP_MEAS);
    drain();
    for (int i = 0; i < 6; i++) send_random(OP_MEAS);
  endtask

  initial begin
    reset_mirror();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    tx_idle_pct = 26;
    rx_idle_pct = 77;
    test_random_phase(130, 16'd64225, 20'd10000, 16'd4);
    test_random_phase(130, 16'd0, 20'd1000000, 16'd1);
    tx_idle_pct = 77;
    rx_idle_pct = 26;
    test_random_phase(130, 16'd65535, 20'd1, 16'd0);
    test_backpressure();
    test_random_phase(130, 16'($urandom), 20'($urandom_range(1, 1000000)),
                      16'($urandom_range(1, 8)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_phase(160, 16'd60000, 20'd2500, 16'd8);
    test_backpressure();
    drain();
    repeat (300) @(posedge clk);
    $display("Covered %0d words (%0d results checked): clear, calibration, measure, no-op,",
             words_sent, words_checked);
    $display("weight/step/count extremes, idle mixes and output back-pressure.");
    if (mismatches == 0 && tilt_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/imu_tcf_pkg.sv
hdl/imu_tcf_div.sv
hdl/imu_tcf_sqrt.sv
hdl/imu_tcf_cordic.sv
hdl/imu_tilt_complementary_filter.sv
tb/imu_tilt_complementary_filter_tb.sv
